/* rtl/frs_pkg.sv */
// ----------------------------------------------------------------------------
// Frame ring slot manager package
// Shared codes, field widths and the configuration control word.
// ----------------------------------------------------------------------------
package frs_pkg;

  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int SLOTS_CFG_W = 7;
  localparam int FRAME_CFG_W = 11;
  localparam int BSIZE_W     = 5;
  localparam int BATCH_W     = 16;
  localparam int ADDR_W      = 16;
  localparam int CNT_W       = 32;

  localparam logic [SLOTS_CFG_W-1:0] SLOTS_RST = SLOTS_CFG_W'(2);
  localparam logic [FRAME_CFG_W-1:0] FRAME_RST = FRAME_CFG_W'(320);
  localparam logic [BSIZE_W-1:0]     BSIZE_RST = BSIZE_W'(4);

  typedef enum logic [1:0] {
    CMD_DMA     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FRAME  = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_OFF    = 2'd2,
    ST_NOREAD = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_SLOTS  = 2'd1,
    REG_FRAME  = 2'd2,
    REG_BATCH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic               enable;
    logic               geom_wr;
    logic [BSIZE_W-1:0] batch;
  } cfg_ctrl_t;

endpackage

/* rtl/frame_ring_slot_manager.sv */
// ----------------------------------------------------------------------------
// Frame ring slot manager
// Slot bookkeeping for a ring of audio frames shared by a DMA producer and a
// consumer: fill and read slots, read tokens, overrun skips and faults.
// ----------------------------------------------------------------------------
// One command word is taken on any cycle with start high; busy stays low, so
// a word can be issued every clock. Each word yields exactly one result,
// shown for one cycle with out_valid starting at the clock edge after the
// word is taken: the taking edge loads the input register, the next edge
// loads the result register through the update logic. The result cannot be
// held off, so the receiver must take it in that cycle. Configuration writes
// take effect at the next edge; the user must issue them only while no word
// is in flight, which the block itself does not enforce. A write of
// ring_enable, ring_slots or frame_samples returns all three heads to slot zero.
// ----------------------------------------------------------------------------
module frame_ring_slot_manager #(
  parameter int MAX_SLOTS   = 64,
  parameter int TOKEN_LIMIT = 16,
  parameter int MAX_FRAME   = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_command,
  input  logic                                 in_released,
  input  logic                                 in_requested,
  input  logic                                 in_fault,
  output logic                                 out_valid,
  output logic                                 out_fill_valid,
  output logic [$clog2(MAX_SLOTS)-1:0]         out_fill_slot,
  output logic [frs_pkg::ADDR_W-1:0]           out_fill_address,
  output logic [1:0]                           out_read_status,
  output logic [$clog2(MAX_SLOTS)-1:0]         out_read_slot,
  output logic [frs_pkg::ADDR_W-1:0]           out_read_address,
  output logic [$clog2(MAX_FRAME+1)-1:0]       out_frame_length,
  output logic                                 out_overrun_skip,
  output logic                                 out_restart_needed,
  output logic [frs_pkg::CNT_W-1:0]            out_fault_total,
  output logic [frs_pkg::CNT_W-1:0]            out_overrun_total,
  output logic [$clog2(TOKEN_LIMIT+1)-1:0]     out_tokens_left,
  input  logic                                 cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frs_pkg::CFG_W-1:0]            cfg_data
);
  import frs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int NS_W   = SLOT_W + 1;
  localparam int FRM_W  = $clog2(MAX_FRAME + 1);
  localparam int TOK_W  = $clog2(TOKEN_LIMIT + 1);

  logic             in_vld_r;
  logic [1:0]       cmd_r;
  logic             rel_r, req_r, flt_r;

  cfg_ctrl_t        ctrl;
  logic [NS_W-1:0]  n_slots;
  logic [FRM_W-1:0] frame_len;

  logic              r_fill_valid;
  logic [SLOT_W-1:0] r_fill_slot;
  logic [ADDR_W-1:0] r_fill_address;
  logic [1:0]        r_read_status;
  logic [SLOT_W-1:0] r_read_slot;
  logic [ADDR_W-1:0] r_read_address;
  logic [FRM_W-1:0]  r_frame_length;
  logic              r_overrun_skip;
  logic              r_restart_needed;
  logic [CNT_W-1:0]  r_fault_total;
  logic [CNT_W-1:0]  r_overrun_total;
  logic [TOK_W-1:0]  r_tokens_left;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r <= in_command;
      rel_r <= in_released;
      req_r <= in_requested;
      flt_r <= in_fault;
    end
  end

  frs_cfg #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_FRAME (MAX_FRAME)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .n_slots   (n_slots),
    .frame_len (frame_len)
  );

  frs_core #(
    .MAX_SLOTS   (MAX_SLOTS),
    .TOKEN_LIMIT (TOKEN_LIMIT),
    .MAX_FRAME   (MAX_FRAME)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_vld           (in_vld_r),
    .cmd                (cmd_r),
    .rel                (rel_r),
    .req                (req_r),
    .flt                (flt_r),
    .ctrl               (ctrl),
    .n_slots            (n_slots),
    .frame_len          (frame_len),
    .res_fill_valid     (r_fill_valid),
    .res_fill_slot      (r_fill_slot),
    .res_fill_address   (r_fill_address),
    .res_read_status    (r_read_status),
    .res_read_slot      (r_read_slot),
    .res_read_address   (r_read_address),
    .res_frame_length   (r_frame_length),
    .res_overrun_skip   (r_overrun_skip),
    .res_restart_needed (r_restart_needed),
    .res_fault_total    (r_fault_total),
    .res_overrun_total  (r_overrun_total),
    .res_tokens_left    (r_tokens_left)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_fill_valid     <= r_fill_valid;
      out_fill_slot      <= r_fill_slot;
      out_fill_address   <= r_fill_address;
      out_read_status    <= r_read_status;
      out_read_slot      <= r_read_slot;
      out_read_address   <= r_read_address;
      out_frame_length   <= r_frame_length;
      out_overrun_skip   <= r_overrun_skip;
      out_restart_needed <= r_restart_needed;
      out_fault_total    <= r_fault_total;
      out_overrun_total  <= r_overrun_total;
      out_tokens_left    <= r_tokens_left;
    end
  end

endmodule

/* rtl/frs_cfg.sv */
// ----------------------------------------------------------------------------
// Frame ring configuration registers
// Holds the ring registers, saturates them to legal values and flags
// geometry writes.
// ----------------------------------------------------------------------------
module frs_cfg #(
  parameter int MAX_SLOTS = 64,
  parameter int MAX_FRAME = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frs_pkg::CFG_W-1:0]            cfg_data,
  output frs_pkg::cfg_ctrl_t                   ctrl,
  output logic [$clog2(MAX_SLOTS):0]           n_slots,
  output logic [$clog2(MAX_FRAME+1)-1:0]       frame_len
);
  import frs_pkg::*;

  localparam int NS_W  = $clog2(MAX_SLOTS) + 1;
  localparam int FRM_W = $clog2(MAX_FRAME + 1);

  logic                   enable_r, enable_nxt;
  logic [SLOTS_CFG_W-1:0] slots_r, slots_nxt;
  logic [FRAME_CFG_W-1:0] frame_r, frame_nxt;
  logic [BSIZE_W-1:0]     bsize_r, bsize_nxt;
  logic                   geom_wr;

  always_comb begin
    enable_nxt = enable_r;
    slots_nxt  = slots_r;
    frame_nxt  = frame_r;
    bsize_nxt  = bsize_r;
    geom_wr    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_ENABLE: begin
          enable_nxt = cfg_data[0];
          geom_wr    = 1'b1;
        end
        REG_SLOTS: begin
          slots_nxt = cfg_data[SLOTS_CFG_W-1:0];
          geom_wr   = 1'b1;
        end
        REG_FRAME: begin
          frame_nxt = cfg_data[FRAME_CFG_W-1:0];
          geom_wr   = 1'b1;
        end
        REG_BATCH: begin
          bsize_nxt = cfg_data[BSIZE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      slots_r  <= SLOTS_RST;
      frame_r  <= FRAME_RST;
      bsize_r  <= BSIZE_RST;
    end else begin
      enable_r <= enable_nxt;
      slots_r  <= slots_nxt;
      frame_r  <= frame_nxt;
      bsize_r  <= bsize_nxt;
    end
  end

  always_comb begin
    if (slots_r < SLOTS_CFG_W'(2)) begin
      n_slots = NS_W'(2);
    end else if (32'(slots_r) > MAX_SLOTS) begin
      n_slots = NS_W'(MAX_SLOTS);
    end else begin
      n_slots = NS_W'(slots_r);
    end
    if (frame_r == '0) begin
      frame_len = FRM_W'(1);
    end else if (32'(frame_r) > MAX_FRAME) begin
      frame_len = FRM_W'(MAX_FRAME);
    end else begin
      frame_len = FRM_W'(frame_r);
    end
  end

  assign ctrl.enable  = enable_r;
  assign ctrl.geom_wr = geom_wr;
  assign ctrl.batch   = (bsize_r == '0) ? BSIZE_W'(1) : bsize_r;

endmodule

/* rtl/frs_core.sv */
// ----------------------------------------------------------------------------
// Frame ring slot manager core
// Ring heads, batch counter, token pool and counters, with the update and
// result logic for one registered word.
// ----------------------------------------------------------------------------
module frs_core #(
  parameter int MAX_SLOTS   = 64,
  parameter int TOKEN_LIMIT = 16,
  parameter int MAX_FRAME   = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  item_vld,
  input  logic [1:0]                            cmd,
  input  logic                                  rel,
  input  logic                                  req,
  input  logic                                  flt,
  input  frs_pkg::cfg_ctrl_t                    ctrl,
  input  logic [$clog2(MAX_SLOTS):0]            n_slots,
  input  logic [$clog2(MAX_FRAME+1)-1:0]        frame_len,
  output logic                                  res_fill_valid,
  output logic [$clog2(MAX_SLOTS)-1:0]          res_fill_slot,
  output logic [frs_pkg::ADDR_W-1:0]            res_fill_address,
  output logic [1:0]                            res_read_status,
  output logic [$clog2(MAX_SLOTS)-1:0]          res_read_slot,
  output logic [frs_pkg::ADDR_W-1:0]            res_read_address,
  output logic [$clog2(MAX_FRAME+1)-1:0]        res_frame_length,
  output logic                                  res_overrun_skip,
  output logic                                  res_restart_needed,
  output logic [frs_pkg::CNT_W-1:0]             res_fault_total,
  output logic [frs_pkg::CNT_W-1:0]             res_overrun_total,
  output logic [$clog2(TOKEN_LIMIT+1)-1:0]      res_tokens_left
);
  import frs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int NS_W   = SLOT_W + 1;
  localparam int LAG_W  = NS_W + 1;
  localparam int FRM_W  = $clog2(MAX_FRAME + 1);
  localparam int TOK_W  = $clog2(TOKEN_LIMIT + 1);
  localparam int SUM_W  = ((TOK_W > BSIZE_W) ? TOK_W : BSIZE_W) + 1;
  localparam int MUL_W  = (SLOT_W + FRM_W > ADDR_W) ? SLOT_W + FRM_W : ADDR_W;

  logic [SLOT_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0]  done_r, done_nxt;
  logic [SLOT_W-1:0]  cons_r, cons_nxt;
  logic [BATCH_W-1:0] batch_r, batch_nxt;
  logic [TOK_W-1:0]   tok_r, tok_nxt;
  logic               restart_r, restart_nxt;
  logic [CNT_W-1:0]   fault_r, fault_nxt;
  logic [CNT_W-1:0]   skip_r, skip_nxt;

  logic [NS_W-1:0]    fill_inc, cons_inc, n_m1;
  logic [SLOT_W-1:0]  fill_step, cons_step, skip_slot, rd_slot;
  logic [LAG_W-1:0]   latest_x, nx_x, lag;
  logic               near_lap;
  logic [BATCH_W-1:0] batch_inc;
  logic [SUM_W-1:0]   tok_sum;
  logic [TOK_W-1:0]   tok_grant;
  logic [MUL_W-1:0]   fill_prod, read_prod;

  // advance heads with compare-and-wrap
  assign fill_inc  = NS_W'(fill_r) + NS_W'(1);
  assign cons_inc  = NS_W'(cons_r) + NS_W'(1);
  assign fill_step = (fill_inc >= n_slots) ? '0 : fill_inc[SLOT_W-1:0];
  assign cons_step = (cons_inc >= n_slots) ? '0 : cons_inc[SLOT_W-1:0];
  assign n_m1      = n_slots - NS_W'(1);

  assign latest_x  = LAG_W'(done_r);
  assign nx_x      = LAG_W'(cons_step);
  assign lag       = (latest_x >= nx_x) ? (latest_x - nx_x)
                                        : (latest_x + LAG_W'(n_slots) - nx_x);
  assign near_lap  = (lag >= LAG_W'(n_m1));
  assign skip_slot = (done_r == '0) ? n_m1[SLOT_W-1:0] : (done_r - SLOT_W'(1));
  assign rd_slot   = near_lap ? skip_slot : cons_step;

  assign fill_prod = MUL_W'(fill_step) * MUL_W'(frame_len);
  assign read_prod = MUL_W'(rd_slot) * MUL_W'(frame_len);

  assign batch_inc = batch_r + BATCH_W'(1);
  assign tok_sum   = SUM_W'(tok_r) + SUM_W'(ctrl.batch);
  assign tok_grant = (32'(tok_sum) > TOKEN_LIMIT) ? TOK_W'(TOKEN_LIMIT)
                                                  : tok_sum[TOK_W-1:0];

  always_comb begin
    fill_nxt         = fill_r;
    done_nxt         = done_r;
    cons_nxt         = cons_r;
    batch_nxt        = batch_r;
    tok_nxt          = tok_r;
    restart_nxt      = restart_r;
    fault_nxt        = fault_r;
    skip_nxt         = skip_r;
    res_fill_valid   = 1'b0;
    res_fill_slot    = '0;
    res_fill_address = '0;
    res_read_status  = ST_NOREAD;
    res_read_slot    = '0;
    res_read_address = '0;
    res_frame_length = '0;
    res_overrun_skip = 1'b0;
    if (item_vld) begin
      unique case (cmd_t'(cmd))
        CMD_DMA: begin
          if (flt) begin
            fault_nxt   = fault_r + CNT_W'(1);
            restart_nxt = 1'b1;
          end else begin
            if (rel) begin
              if (ctrl.enable) begin
                done_nxt = fill_r;
              end
              if (batch_inc >= BATCH_W'(ctrl.batch)) begin
                batch_nxt = '0;
                tok_nxt   = tok_grant;
              end else begin
                batch_nxt = batch_inc;
              end
            end
            if (req && ctrl.enable) begin
              fill_nxt         = fill_step;
              res_fill_valid   = 1'b1;
              res_fill_slot    = fill_step;
              res_fill_address = fill_prod[ADDR_W-1:0];
            end
          end
        end
        CMD_READ: begin
          if (!ctrl.enable) begin
            res_read_status = ST_OFF;
          end else if (tok_r == '0) begin
            res_read_status = ST_EMPTY;
          end else begin
            tok_nxt          = tok_r - TOK_W'(1);
            cons_nxt         = rd_slot;
            res_read_status  = ST_FRAME;
            res_read_slot    = rd_slot;
            res_read_address = read_prod[ADDR_W-1:0];
            res_frame_length = frame_len;
            if (near_lap) begin
              skip_nxt         = skip_r + CNT_W'(1);
              res_overrun_skip = 1'b1;
            end
          end
        end
        CMD_RESTART: begin
          fill_nxt    = '0;
          done_nxt    = '0;
          cons_nxt    = '0;
          tok_nxt     = '0;
          batch_nxt   = '0;
          restart_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    // drop heads on a ring geometry write
    if (ctrl.geom_wr) begin
      fill_nxt = '0;
      done_nxt = '0;
      cons_nxt = '0;
    end
  end

  assign res_restart_needed = restart_nxt;
  assign res_fault_total    = fault_nxt;
  assign res_overrun_total  = skip_nxt;
  assign res_tokens_left    = tok_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      done_r    <= '0;
      cons_r    <= '0;
      batch_r   <= '0;
      tok_r     <= '0;
      restart_r <= 1'b0;
      fault_r   <= '0;
      skip_r    <= '0;
    end else begin
      fill_r    <= fill_nxt;
      done_r    <= done_nxt;
      cons_r    <= cons_nxt;
      batch_r   <= batch_nxt;
      tok_r     <= tok_nxt;
      restart_r <= restart_nxt;
      fault_r   <= fault_nxt;
      skip_r    <= skip_nxt;
    end
  end

endmodule
